// File: rtl/bfde_pkg.sv
// Shared types and constants for the blob field deformation evaluator.
`default_nettype none
package bfde_pkg;

    localparam int COORD_W = 32;
    localparam int WIDTH_W = 31;
    localparam int TERM_W  = 34;
    localparam int ACC_W   = 50;
    localparam int OUT_W   = 48;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    localparam logic CFG_BLOB_COUNT = 1'b0;
    localparam logic CFG_MIN_WIDTH  = 1'b1;

    localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] OUT_MIN = ACC_W'(-(64'sd1 <<< (OUT_W - 1)));

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic signed [COORD_W-1:0] weight;
        logic [WIDTH_W-1:0]        width;
    } blob_entry_t;

    typedef enum logic [2:0] {
        TS_IDLE,
        TS_SQ,
        TS_NORM,
        TS_DIV,
        TS_MUL,
        TS_OUT
    } term_state_t;

    typedef enum logic [2:0] {
        ES_IDLE,
        ES_READ,
        ES_CHECK,
        ES_TERM,
        ES_FINISH
    } eval_state_t;

    function automatic logic [COORD_W-1:0] abs_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        if (d[COORD_W])
        begin
            abs_diff = COORD_W'(-d);
        end
        else
        begin
            abs_diff = d[COORD_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// File: rtl/bfde_if.sv
// Request and result channel interfaces.
`default_nettype none
interface bfde_req_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [5:0]         blob_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic signed [31:0] blob_weight;
    logic [30:0]        blob_width;
    logic signed [31:0] base_value;

    modport source (output valid, action, blob_index, coord_x, coord_y, coord_z,
                    blob_weight, blob_width, base_value, input ready);
    modport sink (input valid, action, blob_index, coord_x, coord_y, coord_z,
                  blob_weight, blob_width, base_value, output ready);
endinterface

interface bfde_res_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] field_value;
    logic               no_blobs;
    logic               saturated;

    modport source (output valid, field_value, no_blobs, saturated, input ready);
    modport sink (input valid, field_value, no_blobs, saturated, output ready);
endinterface
`default_nettype wire

// File: rtl/bfde_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
`default_nettype none
module bfde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// File: rtl/bfde_term.sv
// One blob term: squared distance, normalize, bit-serial ratio, weight multiply.
`default_nettype none
module bfde_term
    import bfde_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic signed [COORD_W-1:0]  px,
    input  wire logic signed [COORD_W-1:0]  py,
    input  wire logic signed [COORD_W-1:0]  pz,
    input  wire blob_entry_t                entry,
    output logic                            done,
    output logic signed [TERM_W-1:0]        term
);
    term_state_t state_reg, state_next;
    logic [COORD_W-1:0]        adx_reg, adx_next;
    logic [COORD_W-1:0]        ady_reg, ady_next;
    logic [COORD_W-1:0]        adz_reg, adz_next;
    logic [WIDTH_W-1:0]        s_reg, s_next;
    logic signed [COORD_W-1:0] w_reg, w_next;
    logic [1:0]                step_reg, step_next;
    logic [65:0]               d_reg, d_next;
    logic [61:0]               n_reg, n_next;
    logic [62:0]               rem_reg, rem_next;
    logic [32:0]               q_reg, q_next;
    logic [5:0]                cnt_reg, cnt_next;
    logic signed [65:0]        prod_reg, prod_next;

    logic [COORD_W-1:0] sq_op;
    logic [63:0]        sq;
    logic [62:0]        trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= TS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        adx_reg  <= adx_next;
        ady_reg  <= ady_next;
        adz_reg  <= adz_next;
        s_reg    <= s_next;
        w_reg    <= w_next;
        step_reg <= step_next;
        d_reg    <= d_next;
        n_reg    <= n_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        prod_reg <= prod_next;
    end

    always_comb
    begin
        case (step_reg)
            2'd0:    sq_op = adx_reg;
            2'd1:    sq_op = ady_reg;
            2'd2:    sq_op = adz_reg;
            default: sq_op = {1'b0, s_reg};
        endcase
        sq = 64'(sq_op) * 64'(sq_op);
        trial = (cnt_reg == 6'd0) ? rem_reg : {rem_reg[61:0], 1'b0};
    end

    always_comb
    begin
        state_next = state_reg;
        adx_next   = adx_reg;
        ady_next   = ady_reg;
        adz_next   = adz_reg;
        s_next     = s_reg;
        w_next     = w_reg;
        step_next  = step_reg;
        d_next     = d_reg;
        n_next     = n_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;
        unique case (state_reg)
            TS_IDLE:
            begin
                if (start)
                begin
                    adx_next   = abs_diff(px, entry.cx);
                    ady_next   = abs_diff(py, entry.cy);
                    adz_next   = abs_diff(pz, entry.cz);
                    s_next     = entry.width;
                    w_next     = entry.weight;
                    step_next  = 2'd0;
                    d_next     = '0;
                    state_next = TS_SQ;
                end
            end
            TS_SQ:
            begin
                d_next    = d_reg + 66'(sq);
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    n_next     = sq[61:0];
                    state_next = TS_NORM;
                end
            end
            TS_NORM:
            begin
                if (d_reg[65:62] != 4'd0)
                begin
                    d_next = d_reg >> 1;
                    n_next = n_reg >> 1;
                end
                else if (d_reg == '0)
                begin
                    q_next     = '0;
                    state_next = TS_MUL;
                end
                else
                begin
                    rem_next   = {1'b0, n_reg};
                    q_next     = '0;
                    cnt_next   = '0;
                    state_next = TS_DIV;
                end
            end
            TS_DIV:
            begin
                if ({3'b0, trial} >= d_reg)
                begin
                    rem_next = trial - d_reg[62:0];
                    q_next   = {q_reg[31:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    q_next   = {q_reg[31:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd32)
                begin
                    state_next = TS_MUL;
                end
            end
            TS_MUL:
            begin
                prod_next  = 66'(w_reg) * $signed({1'b0, q_reg});
                state_next = TS_OUT;
            end
            TS_OUT:
            begin
                state_next = TS_IDLE;
            end
            default:
            begin
                state_next = TS_IDLE;
            end
        endcase
    end

    assign done = (state_reg == TS_OUT);
    assign term = prod_reg[65:32];
endmodule
`default_nettype wire

// File: rtl/blob_field_deformation_eval.sv
// Top level of the blob field deformation evaluator.
// Usage:
//   Requests arrive on the item channel (valid/ready). A load request writes
//   one blob entry into the table and returns nothing; a load to an index at
//   or past MAX_BLOBS is dropped. An evaluate request walks the active blobs
//   and returns one result on the result channel. Configuration (blob_count,
//   min_width) is written through cfg_wr_en, cfg_index and cfg_wdata; the
//   user writes it only while the block is idle; the block does not enforce it.
// Timing:
//   One blob entry is read from the table RAM per step. A skipped blob goes
//   through the read and check states only; a used blob also runs the term
//   unit: squaring steps, normalize, the one-bit per cycle ratio divider
//   and the weight multiply. With blob_count zero an evaluate goes straight
//   to the finish state, which loads the result register.
//   One request is worked on at a time; the next is taken once the
//   result register has been loaded.
// Reset:
//   rst_n clears control state and registers to blob_count 0, min_width 1.
//   Table contents are undefined until loaded.
// Stall:
//   The result holds in its output register until taken; the walk stops
//   before its final step while the output register is still full.
`default_nettype none
module blob_field_deformation_eval
    import bfde_pkg::*;
#(
    parameter int MAX_BLOBS = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_index,
    input  wire logic [30:0] cfg_wdata,
    bfde_req_if.sink        item,
    bfde_res_if.source      result
);
    localparam int AW = (MAX_BLOBS > 1) ? $clog2(MAX_BLOBS) : 1;
    localparam int CW = $clog2(MAX_BLOBS + 1);

    eval_state_t state_reg, state_next;
    logic [6:0]               blob_count_reg;
    logic [WIDTH_W-1:0]       min_width_reg;
    logic [CW-1:0]            idx_reg, idx_next;
    logic [CW-1:0]            n_reg, n_next;
    logic signed [COORD_W-1:0] px_reg, px_next;
    logic signed [COORD_W-1:0] py_reg, py_next;
    logic signed [COORD_W-1:0] pz_reg, pz_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic                     none_reg, none_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0]  out_value_reg, out_value_next;
    logic                     out_none_reg, out_none_next;
    logic                     out_sat_reg, out_sat_next;

    logic                     accept;
    logic                     ram_we;
    logic [$bits(blob_entry_t)-1:0] ram_rdata;
    blob_entry_t              entry;
    blob_entry_t              wr_entry;
    logic                     term_start;
    logic                     term_done;
    logic signed [TERM_W-1:0] term;
    logic [CW-1:0]            idx_inc;

    assign accept = item.valid && item.ready;
    assign item.ready = (state_reg == ES_IDLE);
    assign ram_we = accept && (item.action == ACT_LOAD)
                    && (32'(item.blob_index) < MAX_BLOBS);
    assign wr_entry = '{cx: item.coord_x, cy: item.coord_y, cz: item.coord_z,
                        weight: item.blob_weight, width: item.blob_width};
    assign entry = blob_entry_t'(ram_rdata);
    assign idx_inc = idx_reg + CW'(1);

    bfde_ram #(
        .WIDTH ($bits(blob_entry_t)),
        .DEPTH (MAX_BLOBS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(item.blob_index)),
        .wdata (wr_entry),
        .raddr (AW'(idx_reg)),
        .rdata (ram_rdata)
    );

    bfde_term u_term (
        .clk   (clk),
        .rst_n (rst_n),
        .start (term_start),
        .px    (px_reg),
        .py    (py_reg),
        .pz    (pz_reg),
        .entry (entry),
        .done  (term_done),
        .term  (term)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ES_IDLE;
            blob_count_reg <= '0;
            min_width_reg  <= WIDTH_W'(1);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_BLOB_COUNT: blob_count_reg <= cfg_wdata[6:0];
                    CFG_MIN_WIDTH:  min_width_reg  <= cfg_wdata;
                    default:        blob_count_reg <= blob_count_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        n_reg         <= n_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        pz_reg        <= pz_next;
        acc_reg       <= acc_next;
        none_reg      <= none_next;
        out_value_reg <= out_value_next;
        out_none_reg  <= out_none_next;
        out_sat_reg   <= out_sat_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        pz_next        = pz_reg;
        acc_next       = acc_reg;
        none_next      = none_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_value_next = out_value_reg;
        out_none_next  = out_none_reg;
        out_sat_next   = out_sat_reg;
        term_start     = 1'b0;
        unique case (state_reg)
            ES_IDLE:
            begin
                if (accept && (item.action == ACT_EVAL))
                begin
                    px_next  = item.coord_x;
                    py_next  = item.coord_y;
                    pz_next  = item.coord_z;
                    acc_next = ACC_W'(item.base_value);
                    idx_next = '0;
                    if (32'(blob_count_reg) > MAX_BLOBS)
                    begin
                        n_next = CW'(MAX_BLOBS);
                    end
                    else
                    begin
                        n_next = CW'(blob_count_reg);
                    end
                    if (blob_count_reg == '0)
                    begin
                        none_next  = 1'b1;
                        acc_next   = '0;
                        state_next = ES_FINISH;
                    end
                    else
                    begin
                        none_next  = 1'b0;
                        state_next = ES_READ;
                    end
                end
            end
            ES_READ:
            begin
                state_next = ES_CHECK;
            end
            ES_CHECK:
            begin
                if (entry.width > min_width_reg)
                begin
                    term_start = 1'b1;
                    state_next = ES_TERM;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = (idx_inc == n_reg) ? ES_FINISH : ES_READ;
                end
            end
            ES_TERM:
            begin
                if (term_done)
                begin
                    acc_next   = acc_reg - ACC_W'(term);
                    idx_next   = idx_inc;
                    state_next = (idx_inc == n_reg) ? ES_FINISH : ES_READ;
                end
            end
            ES_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_none_next  = none_reg;
                    if (acc_reg > OUT_MAX)
                    begin
                        out_value_next = OUT_W'(OUT_MAX);
                        out_sat_next   = 1'b1;
                    end
                    else if (acc_reg < OUT_MIN)
                    begin
                        out_value_next = OUT_W'(OUT_MIN);
                        out_sat_next   = 1'b1;
                    end
                    else
                    begin
                        out_value_next = OUT_W'(acc_reg);
                        out_sat_next   = 1'b0;
                    end
                    state_next = ES_IDLE;
                end
            end
            default:
            begin
                state_next = ES_IDLE;
            end
        endcase
    end

    assign result.valid       = out_valid_reg;
    assign result.field_value = out_value_reg;
    assign result.no_blobs    = out_none_reg;
    assign result.saturated   = out_sat_reg;
endmodule
`default_nettype wire
